// ===== sv/lbt_pkg.sv =====
`default_nettype none

package lbt_pkg;

    // table size and field widths
    localparam int ENTRIES  = 8;
    localparam int ID_W     = 31;
    localparam int HANDLE_W = 32;
    localparam int READER_W = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [READER_W-1:0] READER_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD = 3'd4;

    // one table entry as held in a cell
    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic [READER_W-1:0] readers;
        logic                writer;
    } entry_t;

    // lookup result passed from the old end of the row toward the head
    typedef struct packed {
        logic   hit;
        entry_t entry;
    } find_t;

    // per-item control broadcast to every cell
    typedef struct packed {
        logic            shift_all;
        logic            touch;
        logic            release_en;
        logic [ID_W-1:0] id;
    } ctl_t;

endpackage

`default_nettype wire

// ===== sv/lru_buffer_table_with_rw_locks_top.sv =====
`default_nettype none

// LRU buffer table with per-entry reader/writer locks. The table is a row of
// lbt_pkg::ENTRIES cells kept in recency order: the head cell holds the most
// recent entry and the last cell the least recent one. Every command is looked
// up against all cells combinationally; an add of a new id or a read or write
// hit shifts the row back by one place up to the affected cell and puts the
// entry at the head, and an add on a full table pushes the last entry out and
// reports its id. The block takes one command per cycle while its result is
// not stalled and gives that single result in the cycle after acceptance, from
// an output register after the combinational id lookup and ripple select. Reset
// only clears the valid bits, so the table is usable once reset is released.
module lru_buffer_table_with_rw_locks_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lbt_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [lbt_pkg::ID_W-1:0]      s_buffer_id,
    input  wire logic [lbt_pkg::HANDLE_W-1:0]  s_handle_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lbt_pkg::STATUS_W-1:0]       m_status,
    output logic [lbt_pkg::HANDLE_W-1:0]       m_handle_out,
    output logic                               m_evicted_valid,
    output logic [lbt_pkg::ID_W-1:0]           m_evicted_id
);

    localparam int N = lbt_pkg::ENTRIES;

    lbt_pkg::entry_t cell_entry [N];
    lbt_pkg::entry_t cell_prev  [N];
    lbt_pkg::find_t  cell_find  [N+1];
    lbt_pkg::ctl_t   ctl;
    lbt_pkg::entry_t head;
    lbt_pkg::entry_t hit_entry;
    logic            hit;
    logic            accept;
    logic            grant;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [lbt_pkg::STATUS_W-1:0]  status_reg;
    logic [lbt_pkg::STATUS_W-1:0]  status_next;
    logic [lbt_pkg::HANDLE_W-1:0]  handle_reg;
    logic [lbt_pkg::HANDLE_W-1:0]  handle_next;
    logic                          evicted_valid_reg;
    logic                          evicted_valid_next;
    logic [lbt_pkg::ID_W-1:0]      evicted_id_reg;
    logic [lbt_pkg::ID_W-1:0]      evicted_id_next;

    // handshake: the output register frees as it is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // the row of cells, head fed from the decision logic
    assign cell_find[N] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign cell_prev[i] = head;
        end else begin : g_body
            assign cell_prev[i] = cell_entry[i-1];
        end
        lbt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .prev_entry (cell_prev[i]),
            .find_in    (cell_find[i+1]),
            .entry_out  (cell_entry[i]),
            .find_out   (cell_find[i])
        );
    end

    assign hit       = cell_find[0].hit;
    assign hit_entry = cell_find[0].entry;

    // command decode, lock decision and the entry for the head cell
    always_comb begin
        ctl                = '0;
        ctl.id             = s_buffer_id;
        head               = hit_entry;
        grant              = 1'b0;
        status_next        = lbt_pkg::ST_OK;
        handle_next        = '0;
        evicted_valid_next = 1'b0;
        evicted_id_next    = '0;
        unique case (s_cmd)
            lbt_pkg::CMD_ADD: begin
                if (hit) begin
                    status_next = lbt_pkg::ST_DUP;
                end else begin
                    ctl.shift_all      = accept;
                    head.valid         = 1'b1;
                    head.id            = s_buffer_id;
                    head.handle        = s_handle_in;
                    head.readers       = '0;
                    head.writer        = 1'b0;
                    evicted_valid_next = cell_entry[N-1].valid;
                    if (cell_entry[N-1].valid) begin
                        evicted_id_next = cell_entry[N-1].id;
                    end
                end
            end
            lbt_pkg::CMD_READ: begin
                if (!hit) begin
                    status_next = lbt_pkg::ST_MISS;
                end else begin
                    ctl.touch = accept;
                    grant = !hit_entry.writer && (hit_entry.readers != lbt_pkg::READER_MAX);
                    if (grant) begin
                        head.readers = hit_entry.readers
                                       + {{(lbt_pkg::READER_W-1){1'b0}}, 1'b1};
                        handle_next  = hit_entry.handle;
                    end else begin
                        status_next = lbt_pkg::ST_BUSY;
                    end
                end
            end
            lbt_pkg::CMD_WRITE: begin
                if (!hit) begin
                    status_next = lbt_pkg::ST_MISS;
                end else begin
                    ctl.touch = accept;
                    grant = !hit_entry.writer && (hit_entry.readers == '0);
                    if (grant) begin
                        head.writer = 1'b1;
                        handle_next = hit_entry.handle;
                    end else begin
                        status_next = lbt_pkg::ST_BUSY;
                    end
                end
            end
            lbt_pkg::CMD_RELEASE: begin
                if (!hit) begin
                    status_next = lbt_pkg::ST_MISS;
                end else begin
                    ctl.release_en = accept;
                    if (!hit_entry.writer && (hit_entry.readers == '0)) begin
                        status_next = lbt_pkg::ST_NOT_HELD;
                    end
                end
            end
            default: begin
                status_next = lbt_pkg::ST_MISS;
            end
        endcase
    end

    // result register
    always_comb begin
        priority if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            status_reg        <= status_next;
            handle_reg        <= handle_next;
            evicted_valid_reg <= evicted_valid_next;
            evicted_id_reg    <= evicted_id_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_handle_out    = handle_reg;
    assign m_evicted_valid = evicted_valid_reg;
    assign m_evicted_id    = evicted_id_reg;

endmodule

`default_nettype wire

// ===== sv/lbt_cell.sv =====
`default_nettype none

module lbt_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire lbt_pkg::ctl_t  ctl,
    input  wire lbt_pkg::entry_t prev_entry,
    input  wire lbt_pkg::find_t find_in,
    output lbt_pkg::entry_t     entry_out,
    output lbt_pkg::find_t      find_out
);

    lbt_pkg::entry_t entry_reg;
    lbt_pkg::entry_t entry_next;
    lbt_pkg::entry_t released;
    logic            match;
    logic            shift_en;

    // id compare and pass-through of the lookup chain
    assign match = entry_reg.valid && (entry_reg.id == ctl.id);

    always_comb begin
        if (match) begin
            find_out.hit   = 1'b1;
            find_out.entry = entry_reg;
        end else begin
            find_out = find_in;
        end
    end

    // move back one place on add, or when the touched entry sits here or further back
    assign shift_en = ctl.shift_all || (ctl.touch && find_out.hit);

    // release drops the writer first, else one reader
    always_comb begin
        released = entry_reg;
        if (entry_reg.writer) begin
            released.writer = 1'b0;
        end else if (entry_reg.readers != '0) begin
            released.readers = entry_reg.readers - {{(lbt_pkg::READER_W-1){1'b0}}, 1'b1};
        end
    end

    always_comb begin
        priority if (shift_en) begin
            entry_next = prev_entry;
        end else if (ctl.release_en && match) begin
            entry_next = released;
        end else begin
            entry_next = entry_reg;
        end
    end

    // only the valid bit needs reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.id      <= entry_next.id;
        entry_reg.handle  <= entry_next.handle;
        entry_reg.readers <= entry_next.readers;
        entry_reg.writer  <= entry_next.writer;
    end

    assign entry_out = entry_reg;

endmodule

`default_nettype wire

// ===== sv/lbt_checker.sv =====
`default_nettype none

module lbt_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [lbt_pkg::STATUS_W-1:0]  m_status,
    input wire logic [lbt_pkg::HANDLE_W-1:0]  m_handle_out,
    input wire logic                          m_evicted_valid,
    input wire logic [lbt_pkg::ID_W-1:0]      m_evicted_id
);

    // a waiting result is not dropped
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    // an accepted item always yields a result in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    // handle only on a granted acquire
    a_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != lbt_pkg::ST_OK) |-> (m_handle_out == '0))
        else $error("handle shown on a refused item");

    // eviction only on a successful add, and its id is zero otherwise
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_valid |-> (m_status == lbt_pkg::ST_OK) && (m_handle_out == '0))
        else $error("eviction on a non-add item");

    a_evict_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> (m_evicted_id == '0))
        else $error("evicted id without eviction");

endmodule

bind lru_buffer_table_with_rw_locks_top lbt_checker u_lbt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_handle_out    (m_handle_out),
    .m_evicted_valid (m_evicted_valid),
    .m_evicted_id    (m_evicted_id)
);

`default_nettype wire
